// ===== rtl/orb_pkg.sv =====
package orb_pkg;

   // storage geometry
   localparam int DEPTH      = 32;
   localparam int ENTRY_BITS = 32;

   // derived widths
   localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int SUM_BITS = CNT_BITS + 1;

   // fixed field widths of the channels
   localparam int MODE_BITS  = 2;
   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = 6;
   localparam int CAP_BITS   = 6;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(32);

   // operation codes
   localparam logic [MODE_BITS-1:0] MODE_APPEND = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_LIST   = 2'd2;

   typedef logic [IDX_BITS-1:0] idx_type;
   typedef logic [CNT_BITS-1:0] cnt_type;

   // slot of the entry at an offset from the head, wrapped once
   function automatic idx_type slot_of(input idx_type head, input cnt_type offset);
      logic [SUM_BITS-1:0] sum;
      sum = SUM_BITS'(head) + SUM_BITS'(offset);
      if (sum >= SUM_BITS'(DEPTH)) begin
         sum = sum - SUM_BITS'(DEPTH);
      end
      return IDX_BITS'(sum);
   endfunction

endpackage

// ===== rtl/orb_req_if.sv =====
interface orb_req_if
   import orb_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [MODE_BITS-1:0]  mode;
   logic [VALUE_BITS-1:0] entry_value;
   logic [COUNT_BITS-1:0] remove_count;

   modport source (output valid, mode, entry_value, remove_count, input ready);
   modport sink   (input valid, mode, entry_value, remove_count, output ready);
endinterface

// ===== rtl/orb_rsp_if.sv =====
interface orb_rsp_if
   import orb_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] listed_entry;
   logic                  is_last;

   modport source (output valid, listed_entry, is_last, input ready);
   modport sink   (input valid, listed_entry, is_last, output ready);
endinterface

// ===== rtl/orb_ram.sv =====
module orb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port that holds without enable
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/overwrite_ring_buffer_top.sv =====
// Ring buffer that keeps the newest entries and drops the oldest when full.
// req_bus carries one command beat: append an entry, remove a number of the
// oldest entries, or list the whole buffer. rsp_bus carries the entries of a
// list, oldest first, with is_last on the newest; an empty list gives none.
// csr_wr_en/csr_wr_data set the capacity (0 acts as 1, above the storage
// depth acts as the depth); write it only while the block is idle.
// After an append or a remove the next beat can follow at once.
// A list holds req_bus.ready low while a small sequencer walks the entries
// through the shared slot adder and the storage read port: each entry goes
// into the storage read register and then into the output register, and the
// entries follow one per cycle while the receiver takes them.
// A stalled receiver holds the output register and pauses the walk; the
// storage read register keeps the next entry meanwhile, nothing is lost.
// Reset (synchronous) empties the buffer, sets the capacity to the depth and
// drops any beat in flight; the stored words are not cleared.
module overwrite_ring_buffer_top
   import orb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   orb_req_if.sink             req_bus,
   orb_rsp_if.source           rsp_bus,
   input  logic                csr_wr_en,
   input  logic [CAP_BITS-1:0] csr_wr_data
);
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LIST = 1'b1;

   logic                  state_ff, state_in;
   idx_type               head_ff, head_in;
   cnt_type               fill_ff, fill_in;
   cnt_type               walk_ff, walk_in;
   logic [CAP_BITS-1:0]   cap_ff, cap_in;
   logic                  pend_ff, pend_in;
   logic                  pend_last_ff, pend_last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_entry_ff, rsp_entry_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  issue;
   logic                  last_issue;
   logic                  load;
   cnt_type               eff_cap;
   cnt_type               rm_count;
   cnt_type               offset;
   idx_type               slot;
   idx_type               head_inc;
   logic                  wr_en;
   logic [ENTRY_BITS-1:0] rd_data;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   // effective capacity
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CNT_BITS'(1);
      end else if (32'(cap_ff) > 32'(DEPTH)) begin
         eff_cap = CNT_BITS'(DEPTH);
      end else begin
         eff_cap = CNT_BITS'(cap_ff);
      end
   end

   // remove count saturated at the fill
   always_comb begin
      if (32'(req_bus.remove_count) > 32'(fill_ff)) begin
         rm_count = fill_ff;
      end else begin
         rm_count = CNT_BITS'(req_bus.remove_count);
      end
   end

   // shared slot adder: walk position, tail or new head
   always_comb begin
      if (state_ff == ST_LIST) begin
         offset = walk_ff;
      end else if (req_bus.mode == MODE_APPEND) begin
         offset = fill_ff;
      end else begin
         offset = rm_count;
      end
   end
   assign slot = slot_of(head_ff, offset);

   assign head_inc = (head_ff == IDX_BITS'(DEPTH - 1)) ? '0 : head_ff + IDX_BITS'(1);

   // list walk handshake with the read register and output register
   assign load       = pend_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign issue      = (state_ff == ST_LIST) && (!pend_ff || load);
   assign last_issue = (walk_ff + CNT_BITS'(1)) == fill_ff;
   assign wr_en      = accept && (req_bus.mode == MODE_APPEND);

   orb_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot),
      .wr_data (ENTRY_BITS'(req_bus.entry_value)),
      .rd_en   (issue),
      .rd_addr (slot),
      .rd_data (rd_data)
   );

   // command decode and sequencer
   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      fill_in  = fill_ff;
      walk_in  = walk_ff;
      if (accept) begin
         priority if (req_bus.mode == MODE_APPEND) begin
            if (fill_ff < eff_cap) begin
               fill_in = fill_ff + CNT_BITS'(1);
            end else begin
               head_in = head_inc;
            end
         end else if (req_bus.mode == MODE_REMOVE) begin
            fill_in = fill_ff - rm_count;
            head_in = (fill_ff == rm_count) ? '0 : slot;
         end else if (req_bus.mode == MODE_LIST) begin
            if (fill_ff != '0) begin
               state_in = ST_LIST;
               walk_in  = '0;
            end
         end else begin
            state_in = state_ff;
         end
      end
      if (issue) begin
         walk_in = walk_ff + CNT_BITS'(1);
         if (last_issue) begin
            state_in = ST_IDLE;
         end
      end
   end

   // read register tracking and output register
   always_comb begin
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_entry_in = VALUE_BITS'(rd_data);
         rsp_last_in  = pend_last_ff;
         pend_in      = 1'b0;
      end
      if (issue) begin
         pend_in      = 1'b1;
         pend_last_in = last_issue;
      end
   end

   // capacity register
   assign cap_in = csr_wr_en ? csr_wr_data : cap_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         walk_ff      <= '0;
         cap_ff       <= CAP_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         walk_ff      <= walk_in;
         cap_ff       <= cap_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pend_last_ff <= pend_last_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.listed_entry = rsp_entry_ff;
   assign rsp_bus.is_last      = rsp_last_ff;
endmodule

// ===== tb/testbench.sv =====
module testbench
   import orb_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // mode three has no meaning in the block and is dropped
   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned SETTLE_TICKS = 6;

   typedef struct {
      logic [MODE_BITS-1:0]  mode;
      logic [VALUE_BITS-1:0] entry_value;
      logic [COUNT_BITS-1:0] remove_count;
   } ring_cmd_type;

   typedef struct {
      logic [VALUE_BITS-1:0] entry;
      logic                  last;
   } listed_beat_type;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [CAP_BITS-1:0] csr_wr_data;

   orb_req_if req_bus ();
   orb_rsp_if rsp_bus ();

   overwrite_ring_buffer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ring_cmd_type    command_queue [$];
   listed_beat_type listing_queue [$];

   int unsigned sender_idle_pct;
   int unsigned receiver_stall_pct;
   int unsigned error_count;
   int unsigned cycle_count;

   // shadow copy of the ring
   logic [ENTRY_BITS-1:0] shadow_store [DEPTH];
   logic [IDX_BITS-1:0]   shadow_head;
   logic [CNT_BITS-1:0]   shadow_fill;
   logic [CAP_BITS-1:0]   shadow_cap;

   ring_cmd_type    issue_cmd;
   listed_beat_type wanted_beat;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned capacity_limit();
      if (shadow_cap == '0) begin
         return 1;
      end
      if (int'(shadow_cap) > DEPTH) begin
         return DEPTH;
      end
      return int'(shadow_cap);
   endfunction

   function automatic logic [IDX_BITS-1:0] ring_slot(input int unsigned offset);
      return IDX_BITS'((int'(shadow_head) + offset) % DEPTH);
   endfunction

   // advance the shadow ring by one command, queue the entries a list yields
   function automatic void apply_command(input logic [MODE_BITS-1:0] mode,
                                         input logic [VALUE_BITS-1:0] value,
                                         input logic [COUNT_BITS-1:0] count);
      int unsigned     drop;
      int unsigned     k;
      listed_beat_type beat;
      if (mode == MODE_APPEND) begin
         shadow_store[ring_slot(int'(shadow_fill))] = ENTRY_BITS'(value);
         if (shadow_fill < capacity_limit()) begin
            shadow_fill = shadow_fill + CNT_BITS'(1);
         end else begin
            shadow_head = ring_slot(1);
         end
      end else if (mode == MODE_REMOVE) begin
         drop = (count > shadow_fill) ? int'(shadow_fill) : int'(count);
         shadow_head = ring_slot(drop);
         shadow_fill = shadow_fill - CNT_BITS'(drop);
         if (shadow_fill == '0) begin
            shadow_head = '0;
         end
      end else if (mode == MODE_LIST) begin
         for (k = 0; k < shadow_fill; k++) begin
            beat.entry = VALUE_BITS'(shadow_store[ring_slot(k)]);
            beat.last  = (k + 1 == shadow_fill);
            listing_queue.push_back(beat);
         end
      end
   endfunction

   function automatic ring_cmd_type make_cmd(input logic [MODE_BITS-1:0] mode,
                                             input logic [VALUE_BITS-1:0] value,
                                             input logic [COUNT_BITS-1:0] count);
      ring_cmd_type c;
      c.mode         = mode;
      c.entry_value  = value;
      c.remove_count = count;
      return c;
   endfunction

   // random command, append share given in percent
   function automatic ring_cmd_type random_cmd(input int unsigned append_pct);
      int unsigned  roll;
      ring_cmd_type c;
      roll           = $urandom_range(99);
      c.entry_value  = $urandom;
      c.remove_count = ($urandom_range(3) != 0) ? COUNT_BITS'($urandom_range(4))
                                                : COUNT_BITS'($urandom_range(63));
      if (roll < append_pct) begin
         c.mode = MODE_APPEND;
      end else if (roll < append_pct + 15) begin
         c.mode = MODE_REMOVE;
      end else if (roll < 96) begin
         c.mode = MODE_LIST;
      end else begin
         c.mode = MODE_UNUSED;
      end
      return c;
   endfunction

   task automatic report_mismatch(input string what, input logic [VALUE_BITS-1:0] want,
                                  input logic [VALUE_BITS-1:0] got);
      $display("mismatch at %0t: %s, expected %h got %h", $realtime, what, want, got);
      error_count++;
   endtask

   // wait until the block is idle and nothing is outstanding
   task automatic drain_all();
      while (command_queue.size() != 0 || req_bus.valid || listing_queue.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_TICKS) @(negedge clock);
   endtask

   task automatic start_phase(input logic [CAP_BITS-1:0] cap, input int unsigned send_pct,
                              input int unsigned stall_pct);
      drain_all();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en          <= 1'b0;
      sender_idle_pct    = send_pct;
      receiver_stall_pct = stall_pct;
   endtask

   task automatic random_phase(input logic [CAP_BITS-1:0] cap, input int unsigned send_pct,
                               input int unsigned stall_pct, input int unsigned count,
                               input int unsigned append_pct);
      int unsigned  made;
      ring_cmd_type c;
      start_phase(cap, send_pct, stall_pct);
      made = 0;
      while (made < count) begin
         c = random_cmd(append_pct);
         command_queue.push_back(c);
         if (c.mode != MODE_UNUSED) begin
            made++;
         end
      end
   endtask

   // stimulus
   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_bus.valid      = 1'b0;
      req_bus.mode       = MODE_APPEND;
      req_bus.entry_value  = '0;
      req_bus.remove_count = '0;
      rsp_bus.ready      = 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      error_count        = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: full depth, list of empty, extremes, removals, unused mode
      start_phase(CAP_BITS'(DEPTH), 0, 0);
      command_queue.push_back(make_cmd(MODE_LIST, $urandom, '0));
      command_queue.push_back(make_cmd(MODE_APPEND, 32'h0000_0000, 6'd63));
      command_queue.push_back(make_cmd(MODE_APPEND, 32'hFFFF_FFFF, '0));
      command_queue.push_back(make_cmd(MODE_APPEND, 32'hA5A5_5A5A, 6'd21));
      command_queue.push_back(make_cmd(MODE_LIST, $urandom, 6'd42));
      command_queue.push_back(make_cmd(MODE_REMOVE, $urandom, 6'd0));
      command_queue.push_back(make_cmd(MODE_LIST, $urandom, '0));
      command_queue.push_back(make_cmd(MODE_REMOVE, $urandom, 6'd1));
      command_queue.push_back(make_cmd(MODE_LIST, $urandom, '0));
      command_queue.push_back(make_cmd(MODE_UNUSED, $urandom, 6'd2));
      command_queue.push_back(make_cmd(MODE_LIST, $urandom, '0));
      // removal beyond the fill empties the ring
      command_queue.push_back(make_cmd(MODE_REMOVE, $urandom, 6'd63));
      command_queue.push_back(make_cmd(MODE_LIST, $urandom, '0));
      command_queue.push_back(make_cmd(MODE_APPEND, 32'h1234_5678, '0));
      command_queue.push_back(make_cmd(MODE_REMOVE, $urandom, 6'd32));
      command_queue.push_back(make_cmd(MODE_LIST, $urandom, '0));
      command_queue.push_back(make_cmd(MODE_APPEND, $urandom, '0));
      command_queue.push_back(make_cmd(MODE_APPEND, $urandom, '0));
      command_queue.push_back(make_cmd(MODE_APPEND, $urandom, '0));

      // capacity zero acts as one, and sits below the current fill
      start_phase('0, 0, 0);
      command_queue.push_back(make_cmd(MODE_APPEND, $urandom, '0));
      command_queue.push_back(make_cmd(MODE_LIST, $urandom, '0));
      command_queue.push_back(make_cmd(MODE_REMOVE, $urandom, 6'd2));
      command_queue.push_back(make_cmd(MODE_APPEND, $urandom, '0));
      command_queue.push_back(make_cmd(MODE_APPEND, $urandom, '0));
      command_queue.push_back(make_cmd(MODE_LIST, $urandom, '0));

      // random phases across capacities and idle patterns
      random_phase(6'd63, 0, 0, 25, 70);
      random_phase(6'd33, 49, 0, 15, 55);
      random_phase(6'd5, 0, 49, 15, 50);
      random_phase(6'd1, 35, 35, 10, 50);
      random_phase(CAP_BITS'($urandom_range(63)), 49, 0, 15, 55);
      random_phase(CAP_BITS'(DEPTH), 35, 35, 15, 60);

      drain_all();
      repeat (10) @(posedge clock);
      if (error_count == 0 && listing_queue.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // command driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (command_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            issue_cmd = command_queue.pop_front();
            req_bus.valid        <= 1'b1;
            req_bus.mode         <= issue_cmd.mode;
            req_bus.entry_value  <= issue_cmd.entry_value;
            req_bus.remove_count <= issue_cmd.remove_count;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // track capacity writes and accepted command beats
   always @(posedge clock) begin
      if (reset) begin
         shadow_head = '0;
         shadow_fill = '0;
         shadow_cap  = CAP_RESET;
      end else begin
         if (csr_wr_en) begin
            shadow_cap = csr_wr_data;
         end
         if (req_bus.valid && req_bus.ready) begin
            apply_command(req_bus.mode, req_bus.entry_value, req_bus.remove_count);
         end
      end
   end

   // compare each listed beat with the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (listing_queue.size() == 0) begin
            report_mismatch("beat with nothing expected", '0, rsp_bus.listed_entry);
         end else begin
            wanted_beat = listing_queue.pop_front();
            if (rsp_bus.listed_entry !== wanted_beat.entry) begin
               report_mismatch("listed_entry", wanted_beat.entry, rsp_bus.listed_entry);
            end
            if (rsp_bus.is_last !== wanted_beat.last) begin
               report_mismatch("is_last", VALUE_BITS'(wanted_beat.last),
                               VALUE_BITS'(rsp_bus.is_last));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      cycle_count = 0;
   end

endmodule

// ===== files.f =====
rtl/orb_pkg.sv
rtl/orb_req_if.sv
rtl/orb_rsp_if.sv
rtl/orb_ram.sv
rtl/overwrite_ring_buffer_top.sv
tb/testbench.sv
